// ===== rtl/core/bole_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bole_pkg
// Shared types and codes for the bounded ordered list engine.
// ----------------------------------------------------------------------------
package bole_pkg;

  localparam int unsigned DATA_W      = 32;
  localparam int unsigned FUNC_W      = 2;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned COUNT_OUT_W = 5;

  // Request function codes.
  localparam logic [FUNC_W-1:0] FUNC_PUSH_FRONT = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_PUSH_BACK  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_REMOVE     = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_SHOW       = 2'd3;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY   = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_MISSING = 2'd3;

  // Operation broadcast to every cell of the chain.
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_PUSH_FRONT,
    CELL_PUSH_BACK,
    CELL_REMOVE,
    CELL_ROTATE
  } cell_op_e;

  typedef struct packed {
    cell_op_e                  op;
    logic signed [DATA_W-1:0]  value;
  } cell_ctrl_t;

endpackage

// ===== rtl/core/bole_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bole_cell
// One list position: holds an entry, compares it and shifts with neighbors.
// ----------------------------------------------------------------------------
module bole_cell import bole_pkg::*; #(
  parameter int unsigned IDX   = 0,
  parameter int unsigned CNT_W = 5
) (
  input  logic                     clk_i,
  input  cell_ctrl_t               ctrl_i,
  input  logic [CNT_W-1:0]         count_i,
  input  logic [CNT_W-1:0]         tail_i,
  input  logic signed [DATA_W-1:0] left_i,
  input  logic signed [DATA_W-1:0] right_i,
  input  logic signed [DATA_W-1:0] head_i,
  input  logic                     hit_i,
  output logic                     hit_o,
  output logic signed [DATA_W-1:0] data_o
);

  localparam logic [CNT_W-1:0] IdxC = CNT_W'(IDX);

  logic signed [DATA_W-1:0] data_q, data_d;
  logic                     used;

  assign used   = (IdxC < count_i);
  // The hit chain marks the first matching position and everything behind it.
  assign hit_o  = hit_i | (used && (data_q == ctrl_i.value));
  assign data_o = data_q;

  always_comb begin
    data_d = data_q;
    case (ctrl_i.op)
      CELL_PUSH_FRONT: data_d = left_i;
      CELL_PUSH_BACK: begin
        if (IdxC == count_i) data_d = ctrl_i.value;
      end
      CELL_REMOVE: begin
        if (hit_o) data_d = right_i;
      end
      CELL_ROTATE: begin
        data_d = (IdxC == tail_i) ? head_i : right_i;
      end
      default: data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

endmodule

// ===== rtl/core/bounded_ordered_list_engine_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_ordered_list_engine_top
// Ordered list of up to CAPACITY signed 32-bit values in a chain of cells.
// ----------------------------------------------------------------------------
// The list lives in a row of CAPACITY cells, one entry per cell, with the
// first entry in cell zero. Insert at front shifts the whole row one place
// toward the tail, insert at end writes the cell just past the last entry,
// and delete compares every cell with the value at once: a hit signal runs
// down the chain from the first match, and each cell it marks takes its
// right neighbor. Each of these requests gives one result. In a display of
// n entries the row rotates one place per cycle unless the output stalls,
// within the first n cells; cell zero feeds the output, and after n steps
// the list is back in its original order. An empty list gives a single
// result with status empty. Inserting into a full list is refused with
// status full; deleting a missing value gives status not found. A new
// request is taken only when the previous one has finished, while a result
// still waiting in the output register may be taken at the same edge.
// The reported entry count is the count after the request, modulo 32.
// ----------------------------------------------------------------------------
module bounded_ordered_list_engine_top import bole_pkg::*; #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [FUNC_W-1:0]             func_i,
  input  logic signed [DATA_W-1:0]      value_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [STATUS_W-1:0]           status_o,
  output logic signed [DATA_W-1:0]      entry_o,
  output logic [COUNT_OUT_W-1:0]        entry_count_o,
  output logic                          last_o
);

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CapC = CNT_W'(CAPACITY);

  typedef enum logic {
    ST_IDLE,
    ST_SHOW
  } state_e;

  state_e                    state_q;
  logic [CNT_W-1:0]          count_q;
  logic [CNT_W-1:0]          idx_q;
  logic [CNT_W-1:0]          tail;
  logic                      out_valid_q;
  logic [STATUS_W-1:0]       status_q;
  logic signed [DATA_W-1:0]  entry_q;
  logic [COUNT_OUT_W-1:0]    entry_count_q;
  logic                      last_q;

  logic                      out_free;
  logic                      in_acc;
  logic                      full;
  logic                      found;
  cell_ctrl_t                ctrl;

  logic signed [DATA_W-1:0]  data_w [CAPACITY];
  logic [CAPACITY:0]         hit_w;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE) || !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign full       = (count_q >= CapC);
  assign tail       = count_q - 1'b1;
  assign found      = hit_w[CAPACITY];

  // Decode the request into the operation every cell sees this cycle.
  always_comb begin
    ctrl.op    = CELL_HOLD;
    ctrl.value = value_i;
    if (in_acc) begin
      case (func_i)
        FUNC_PUSH_FRONT: if (!full) ctrl.op = CELL_PUSH_FRONT;
        FUNC_PUSH_BACK:  if (!full) ctrl.op = CELL_PUSH_BACK;
        FUNC_REMOVE:     ctrl.op = CELL_REMOVE;
        default:         ctrl.op = CELL_HOLD;
      endcase
    end else if (state_q == ST_SHOW && out_free) begin
      ctrl.op = CELL_ROTATE;
    end
  end

  assign hit_w[0] = 1'b0;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic signed [DATA_W-1:0] left_s, right_s;
    if (g == 0) begin : g_first
      assign left_s = value_i;
    end else begin : g_mid
      assign left_s = data_w[g-1];
    end
    if (g == CAPACITY - 1) begin : g_end
      assign right_s = data_w[g];
    end else begin : g_inner
      assign right_s = data_w[g+1];
    end

    bole_cell #(
      .IDX   (g),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .count_i (count_q),
      .tail_i  (tail),
      .left_i  (left_s),
      .right_i (right_s),
      .head_i  (data_w[0]),
      .hit_i   (hit_w[g]),
      .hit_o   (hit_w[g+1]),
      .data_o  (data_w[g])
    );
  end

  // Request sequencing, entry count and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      count_q       <= '0;
      idx_q         <= '0;
      out_valid_q   <= 1'b0;
      status_q      <= STATUS_OK;
      entry_q       <= '0;
      entry_count_q <= '0;
      last_q        <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;

      if (in_acc) begin
        out_valid_q   <= 1'b1;
        entry_q       <= '0;
        last_q        <= 1'b1;
        status_q      <= STATUS_OK;
        entry_count_q <= COUNT_OUT_W'(count_q);
        case (func_i)
          FUNC_PUSH_FRONT, FUNC_PUSH_BACK: begin
            if (full) begin
              status_q <= STATUS_FULL;
            end else begin
              count_q       <= count_q + 1'b1;
              entry_count_q <= COUNT_OUT_W'(count_q + 1'b1);
            end
          end
          FUNC_REMOVE: begin
            if (count_q == '0) begin
              status_q <= STATUS_EMPTY;
            end else if (found) begin
              count_q       <= tail;
              entry_count_q <= COUNT_OUT_W'(tail);
            end else begin
              status_q <= STATUS_MISSING;
            end
          end
          default: begin
            if (count_q == '0) begin
              status_q <= STATUS_EMPTY;
            end else begin
              // The first entry goes out from the display state.
              out_valid_q <= 1'b0;
              state_q     <= ST_SHOW;
              idx_q       <= '0;
            end
          end
        endcase
      end else if (state_q == ST_SHOW && out_free) begin
        out_valid_q   <= 1'b1;
        status_q      <= STATUS_OK;
        entry_q       <= data_w[0];
        entry_count_q <= COUNT_OUT_W'(count_q);
        last_q        <= (idx_q == tail);
        idx_q         <= idx_q + 1'b1;
        if (idx_q == tail) state_q <= ST_IDLE;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign entry_o       = entry_q;
  assign entry_count_o = entry_count_q;
  assign last_o        = last_q;

endmodule

// ===== tb/bounded_ordered_list_engine_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_ordered_list_engine_top_test
// Self-checking bench for the bounded ordered list engine.
// ----------------------------------------------------------------------------
// An initial block fills a queue of pending requests: a short directed
// opening, then phases of random requests that alternately shrink and grow
// the list. A clocked driver offers them on the request channel. Each
// accepted request goes through a shadow of the list kept here, and the
// results that request must produce are appended to a queue. A clocked
// monitor takes every accepted result and compares it field by field with
// the oldest one waiting. The result-side stall comes from its own process,
// with short random bursts and one long hold-off that backs the engine up.
// ----------------------------------------------------------------------------
module bounded_ordered_list_engine_top_test;
  import bole_pkg::*;

  localparam int unsigned LIST_CAP       = 16;
  localparam int unsigned RX_HOLD_CYCLES = 60;
  localparam int unsigned PHASE_LEN      = 20;
  localparam int unsigned NUM_PHASES     = 10;
  // The timeout leaves ample margin for the slowest legal run.
  localparam time         TIMEOUT_NS     = 1_000_000;

  // One result of the engine, as the shadow list predicts it.
  typedef struct packed {
    logic [STATUS_W-1:0]     status;
    logic signed [DATA_W-1:0] entry;
    logic [COUNT_OUT_W-1:0]  entry_count;
    logic                    last;
  } list_result_t;

  // One request waiting to be offered, with the pacing hints that go with it.
  typedef struct {
    logic [FUNC_W-1:0]        fn;
    logic signed [DATA_W-1:0] val;
    bit                       calm;        // no idling on either side
    bit                       wait_drain;  // hold back until nothing is due
    bit                       choke;       // start the long receiver hold-off
  } list_request_t;

  logic                      clk_i = 1'b0;
  logic                      rst_ni;
  logic                      in_valid_i;
  logic                      in_stall_o;
  logic [FUNC_W-1:0]         func_i;
  logic signed [DATA_W-1:0]  value_i;
  logic                      out_valid_o;
  logic                      out_stall_i;
  logic [STATUS_W-1:0]       status_o;
  logic signed [DATA_W-1:0]  entry_o;
  logic [COUNT_OUT_W-1:0]    entry_count_o;
  logic                      last_o;

  list_request_t             pending_q[$];
  list_result_t              due_results_q[$];

  // Shadow of the engine's list, first entry at index zero.
  logic signed [DATA_W-1:0]  held_vals [LIST_CAP];
  int unsigned               held_count = 0;

  // List contents as the stimulus generator expects them, used to aim
  // deletes at values that are actually present.
  logic signed [DATA_W-1:0]  plan_vals[$];

  int unsigned gap_left       = 0;
  int unsigned hold_left      = 0;
  int unsigned burst_left     = 0;
  bit          hold_go        = 1'b0;
  bit          calm_now       = 1'b0;

  int unsigned mismatches     = 0;
  int unsigned requests_done  = 0;
  int unsigned results_seen   = 0;
  int unsigned full_refusals  = 0;
  int unsigned empty_hits     = 0;
  int unsigned missing_hits   = 0;
  int unsigned shows_done     = 0;

  bounded_ordered_list_engine_top #(
    .CAPACITY(LIST_CAP)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .func_i       (func_i),
    .value_i      (value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_o     (status_o),
    .entry_o      (entry_o),
    .entry_count_o(entry_count_o),
    .last_o       (last_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Prints one line per mismatch. Printing stops after the first hundred so
  // that a badly broken engine cannot flood the log; counting goes on.
  task automatic report_mismatch(input string what);
    if (mismatches < 100) begin
      $display("ERROR at %0t ns: %s", $time, what);
    end
    mismatches++;
  endtask

  // Applies one accepted request to the shadow list and queues the results
  // the engine owes for it. Every result carries the count after the update.
  task automatic apply_list_op(input logic [FUNC_W-1:0] fn,
                               input logic signed [DATA_W-1:0] val);
    list_result_t r;
    int           hit;
    r.status = STATUS_OK;
    r.entry  = '0;
    r.last   = 1'b1;
    hit      = -1;
    case (fn)
      FUNC_PUSH_FRONT, FUNC_PUSH_BACK: begin
        if (held_count >= LIST_CAP) begin
          r.status = STATUS_FULL;
          full_refusals++;
        end else if (fn == FUNC_PUSH_FRONT) begin
          for (int i = held_count; i > 0; i--) begin
            held_vals[i] = held_vals[i-1];
          end
          held_vals[0] = val;
          held_count++;
        end else begin
          held_vals[held_count] = val;
          held_count++;
        end
      end
      FUNC_REMOVE: begin
        for (int i = 0; i < held_count; i++) begin
          if (hit < 0 && held_vals[i] == val) begin
            hit = i;
          end
        end
        if (held_count == 0) begin
          r.status = STATUS_EMPTY;
          empty_hits++;
        end else if (hit < 0) begin
          r.status = STATUS_MISSING;
          missing_hits++;
        end else begin
          // Only the first match goes; the entries behind it close up.
          for (int i = hit; i + 1 < held_count; i++) begin
            held_vals[i] = held_vals[i+1];
          end
          held_count--;
        end
      end
      default: begin
        shows_done++;
        if (held_count == 0) begin
          r.status = STATUS_EMPTY;
          empty_hits++;
        end else begin
          // A show streams the whole list, marking only its final entry.
          r.entry_count = COUNT_OUT_W'(held_count);
          for (int i = 0; i < held_count; i++) begin
            r.entry = held_vals[i];
            r.last  = (i + 1 == held_count);
            due_results_q.push_back(r);
          end
          return;
        end
      end
    endcase
    r.entry_count = COUNT_OUT_W'(held_count);
    due_results_q.push_back(r);
  endtask

  // Request driver. A request stays on the port until it is taken; between
  // requests the driver may idle for a short random burst.
  always @(posedge clk_i) begin : request_driver
    list_request_t nxt;
    logic          offer;
    bit            go_hold;
    go_hold = 1'b0;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        apply_list_op(func_i, value_i);
        requests_done++;
      end
      offer = in_valid_i && in_stall_o;
      if (!offer) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
        end else if (pending_q.size() != 0 &&
                     !(pending_q[0].wait_drain && due_results_q.size() != 0)) begin
          if (!pending_q[0].calm && $urandom_range(0, 4) == 0) begin
            gap_left <= $urandom_range(1, 8) - 1;
          end else begin
            nxt = pending_q.pop_front();
            func_i   <= nxt.fn;
            value_i  <= nxt.val;
            calm_now <= nxt.calm;
            go_hold  = nxt.choke;
            offer    = 1'b1;
          end
        end
      end
      in_valid_i <= offer;
    end else begin
      in_valid_i <= 1'b0;
      func_i     <= FUNC_SHOW;
      value_i    <= '0;
    end
    hold_go <= go_hold;
  end

  // Result-side stall. The long hold-off lets the output register fill so
  // that the engine has to stall the request channel behind it.
  always @(posedge clk_i) begin : result_stall
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else if (hold_go) begin
      hold_left   <= RX_HOLD_CYCLES - 1;
      out_stall_i <= 1'b1;
    end else if (burst_left != 0) begin
      burst_left  <= burst_left - 1;
      out_stall_i <= 1'b1;
    end else if (!calm_now && $urandom_range(0, 5) == 0) begin
      burst_left  <= $urandom_range(1, 8) - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Result monitor: every accepted result is matched against the oldest
  // prediction still waiting.
  always @(posedge clk_i) begin : result_monitor
    list_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (due_results_q.size() == 0) begin
        report_mismatch($sformatf("result with none due: status %0d entry %0d count %0d",
                                  status_o, entry_o, entry_count_o));
      end else begin
        want = due_results_q.pop_front();
        if (status_o !== want.status) begin
          report_mismatch($sformatf("status %0d, want %0d", status_o, want.status));
        end
        if (entry_o !== want.entry) begin
          report_mismatch($sformatf("entry %0d, want %0d", entry_o, want.entry));
        end
        if (entry_count_o !== want.entry_count) begin
          report_mismatch($sformatf("entry_count %0d, want %0d",
                                    entry_count_o, want.entry_count));
        end
        if (last_o !== want.last) begin
          report_mismatch($sformatf("last %0b, want %0b", last_o, want.last));
        end
      end
    end
  end

  // Values lean on the extremes and on a small set, so that duplicates and
  // delete hits come up often, while full-width values exercise every bit.
  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2:       return '0;
      3:       return '1;
      4, 5:    return $urandom_range(1, 9);
      default: return $urandom();
    endcase
  endfunction

  // Queues a request and tracks what the list should hold once it is done.
  task automatic add_request(input logic [FUNC_W-1:0] fn,
                             input logic signed [DATA_W-1:0] val,
                             input bit calm, input bit wait_drain, input bit choke);
    list_request_t q;
    int            hit;
    q.fn         = fn;
    q.val        = val;
    q.calm       = calm;
    q.wait_drain = wait_drain;
    q.choke      = choke;
    pending_q.push_back(q);
    hit = -1;
    case (fn)
      FUNC_PUSH_FRONT: if (plan_vals.size() < LIST_CAP) plan_vals.push_front(val);
      FUNC_PUSH_BACK:  if (plan_vals.size() < LIST_CAP) plan_vals.push_back(val);
      FUNC_REMOVE: begin
        foreach (plan_vals[i]) begin
          if (hit < 0 && plan_vals[i] == val) begin
            hit = i;
          end
        end
        if (hit >= 0) begin
          plan_vals.delete(hit);
        end
      end
      default: ;
    endcase
  endtask

  initial begin : stimulus
    logic [FUNC_W-1:0]        fn;
    logic signed [DATA_W-1:0] val;
    bit                       grow;
    bit                       calm;
    int unsigned              roll;
    rst_ni      = 1'b0;

    // Directed opening: operations on an empty list, the value extremes,
    // a missing value, duplicates, then a fill to capacity and refusals.
    add_request(FUNC_SHOW,       32'sd5,          0, 0, 0);
    add_request(FUNC_REMOVE,     32'sd5,          0, 0, 0);
    add_request(FUNC_PUSH_FRONT, 32'sh7FFF_FFFF,  0, 0, 0);
    add_request(FUNC_PUSH_BACK,  32'sh8000_0000,  0, 0, 0);
    add_request(FUNC_PUSH_FRONT, '0,              0, 0, 0);
    add_request(FUNC_PUSH_BACK,  '1,              0, 0, 0);
    add_request(FUNC_SHOW,       '1,              0, 0, 0);
    add_request(FUNC_REMOVE,     32'sd12345,      0, 0, 0);
    // Two copies of one value, one at each end; the delete must take the
    // one at the front.
    add_request(FUNC_PUSH_FRONT, 32'sd7,          0, 0, 0);
    add_request(FUNC_PUSH_BACK,  32'sd7,          0, 0, 0);
    add_request(FUNC_REMOVE,     32'sd7,          0, 0, 0);
    add_request(FUNC_SHOW,       '0,              0, 0, 0);
    while (plan_vals.size() < LIST_CAP) begin
      add_request(($urandom_range(0, 1) != 0) ? FUNC_PUSH_FRONT : FUNC_PUSH_BACK,
                  pick_value(), 0, 0, 0);
    end
    add_request(FUNC_PUSH_FRONT, 32'sd1,          0, 0, 0);
    add_request(FUNC_PUSH_BACK,  32'sd2,          0, 0, 0);
    add_request(FUNC_SHOW,       '0,              0, 0, 0);

    // Random phases alternate between draining and filling the list, so the
    // count sweeps from empty to full several times. The last phase runs
    // without idling on either side.
    for (int p = 0; p < NUM_PHASES; p++) begin
      grow = (p % 2) == 1;
      calm = (p == NUM_PHASES - 1) || (p % 3 == 1);
      for (int k = 0; k < PHASE_LEN; k++) begin
        roll = $urandom_range(0, 99);
        val  = pick_value();
        if (grow) begin
          fn = (roll < 35) ? FUNC_PUSH_FRONT : (roll < 70) ? FUNC_PUSH_BACK :
               (roll < 85) ? FUNC_REMOVE : FUNC_SHOW;
        end else begin
          fn = (roll < 12) ? FUNC_PUSH_FRONT : (roll < 24) ? FUNC_PUSH_BACK :
               (roll < 88) ? FUNC_REMOVE : FUNC_SHOW;
        end
        if (fn == FUNC_REMOVE && plan_vals.size() != 0 && $urandom_range(0, 3) != 0) begin
          val = plan_vals[$urandom_range(0, plan_vals.size() - 1)];
        end
        // Early on, the receiver holds off for a long stretch; midway, the
        // sender waits until every outstanding result has come back.
        add_request(fn, val, calm, (p == 5 && k == 0), (p == 2 && k == 0));
      end
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_q.size() != 0 || in_valid_i) @(posedge clk_i);
    while (due_results_q.size() != 0) @(posedge clk_i);
    // A show of a full list is the longest request; let any stray output
    // surface before the verdict.
    repeat (LIST_CAP + 8) @(posedge clk_i);

    $display("Run covered %0d requests and %0d results: %0d shows, %0d full refusals,",
             requests_done, results_seen, shows_done, full_refusals);
    $display("%0d empty-list and %0d not-found outcomes; %0d field mismatches.",
             empty_hits, missing_hits, mismatches);
    if (mismatches == 0) begin
      $display("bounded_ordered_list_engine_top: match");
    end else begin
      $display("bounded_ordered_list_engine_top: mismatch");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("Timed out with %0d results still due.", due_results_q.size());
    $display("bounded_ordered_list_engine_top: mismatch");
    $finish;
  end

endmodule
